// ===== rtl/core/bpl_pkg.sv =====
`timescale 1ns / 1ps

package bpl_pkg;

  // Default number of buckets in each table.
  localparam int unsigned BucketsDef = 20;

  // Field widths.
  localparam int unsigned RateW    = 16;
  localparam int unsigned FitW     = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned LrW      = 17;
  localparam int unsigned InDataW  = 2 * RateW + FitW;
  localparam int unsigned OutDataW = 2 * RateW;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = LrW;
  localparam int unsigned ProdW    = FitW + LrW + 2;

  // Register reset values and limits.
  localparam logic [LrW-1:0]  LrReset  = 17'd6554;
  localparam logic [LrW-1:0]  LrOne    = 17'd65536;
  localparam logic [CntW-1:0] MinReset = 16'd1;
  localparam logic [CntW-1:0] CntMax   = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLearningRate = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMinSamples   = 1'b1;

  // Input beat kinds carried in tuser.
  localparam logic ActObserve = 1'b0;
  localparam logic ActClear   = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StFind,
    StCalc,
    StWrite,
    StScan,
    StDrain,
    StResult
  } state_e;

  // One bucket: sample count and Q16.16 average fitness.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [FitW-1:0] avg;
  } entry_t;

endpackage

// ===== rtl/core/bucketed_parameter_learner.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: rates, fitness
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: valid_res; tdata: best centres
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// An observe beat passes through the find, calc, write, scan, drain and result
// states; a clear beat goes straight to the result state. The recommendation
// scan reads one entry per cycle from each table memory.
// Reset clears the per-entry valid bits at once, so there is no clearing pass.
// The finished result sits in an output register; the next input beat is taken
// while it waits, and the block only holds in its result state if the register
// is still occupied when the next result is ready.

module bucketed_parameter_learner #(
  parameter int unsigned Buckets = bpl_pkg::BucketsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] mut_rate, [31:16] exploration, [63:32] fitness
  input  logic [bpl_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] best_mut_rate, [31:16] best_exploration
  output logic [bpl_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] valid_res
  output logic                           m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bpl_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW  = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned RateW = bpl_pkg::RateW;
  localparam int unsigned FitW  = bpl_pkg::FitW;
  localparam int unsigned CntW  = bpl_pkg::CntW;
  localparam int unsigned LrW   = bpl_pkg::LrW;
  localparam int unsigned ProdW = bpl_pkg::ProdW;

  // Bucket centres as Q0.16 constants. Mutation centres are 0.01 + 0.02*i,
  // exploration centres i/Buckets, both rounded half up and saturated.
  logic [RateW-1:0] mut_ctr  [Buckets];
  logic [RateW-1:0] expl_ctr [Buckets];

  for (genvar g = 0; g < Buckets; g++) begin : g_ctr
    localparam int unsigned MutRaw  = ((1 + 2 * g) * 65536 + 50) / 100;
    localparam int unsigned ExplRaw = (g * 65536 + Buckets / 2) / Buckets;
    assign mut_ctr[g]  = (MutRaw > 65535) ? {RateW{1'b1}} : RateW'(MutRaw);
    assign expl_ctr[g] = (ExplRaw > 65535) ? {RateW{1'b1}} : RateW'(ExplRaw);
  end

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
  logic [LrW-1:0]  lr_q, lr_d;
  logic [CntW-1:0] min_q, min_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    lr_d  = lr_q;
    min_d = min_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpl_pkg::RegLearningRate: lr_d  = cfg_data_i;
        bpl_pkg::RegMinSamples:   min_d = cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  bpl_pkg::state_e state_q, state_d;
  logic            s_hs;
  logic            observed_q, observed_d;
  logic [IdxW-1:0] scan_cnt_q, scan_cnt_d;
  logic            cmp_en_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            mem_we;
  logic            out_load;
  logic            out_valid_q, out_valid_d;
  logic            out_user_q;
  logic [bpl_pkg::OutDataW-1:0] out_data_q;

  // Captured input beat.
  logic             act_q;
  logic [RateW-1:0] mut_val_q, expl_val_q;
  logic [FitW-1:0]  fit_q;

  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == bpl_pkg::StIdle);

  always_comb begin
    state_d    = state_q;
    observed_d = observed_q;
    scan_cnt_d = scan_cnt_q;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      bpl_pkg::StIdle: begin
        if (s_hs) begin
          if (s_axis_tuser == bpl_pkg::ActClear) begin
            observed_d = 1'b0;
            state_d    = bpl_pkg::StResult;
          end else begin
            state_d = bpl_pkg::StFind;
          end
        end
      end
      bpl_pkg::StFind:  state_d = bpl_pkg::StCalc;
      bpl_pkg::StCalc:  state_d = bpl_pkg::StWrite;
      bpl_pkg::StWrite: begin
        mem_we     = 1'b1;
        observed_d = 1'b1;
        scan_cnt_d = '0;
        state_d    = bpl_pkg::StScan;
      end
      bpl_pkg::StScan: begin
        if (scan_cnt_q == IdxW'(Buckets - 1)) begin
          state_d = bpl_pkg::StDrain;
        end else begin
          scan_cnt_d = scan_cnt_q + IdxW'(1);
        end
      end
      bpl_pkg::StDrain: state_d = bpl_pkg::StResult;
      bpl_pkg::StResult: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = bpl_pkg::StIdle;
        end
      end
      default: state_d = bpl_pkg::StIdle;
    endcase
  end

  // Nearest centre. Centres do not decrease with the index, so the nearest
  // bucket (ties to the lower index) is the number of midpoints that the
  // value lies strictly above.
  logic [IdxW-1:0] mut_near, expl_near;

  always_comb begin
    mut_near  = '0;
    expl_near = '0;
    for (int j = 0; j < Buckets - 1; j++) begin
      if ({mut_val_q, 1'b0} > ({1'b0, mut_ctr[j]} + {1'b0, mut_ctr[j+1]})) begin
        mut_near = mut_near + IdxW'(1);
      end
      if ({expl_val_q, 1'b0} > ({1'b0, expl_ctr[j]} + {1'b0, expl_ctr[j+1]})) begin
        expl_near = expl_near + IdxW'(1);
      end
    end
  end

  logic [IdxW-1:0] mut_idx_q, expl_idx_q;
  logic [IdxW-1:0] mut_raddr, expl_raddr;

  assign mut_raddr  = (state_q == bpl_pkg::StFind) ? mut_near  : scan_cnt_q;
  assign expl_raddr = (state_q == bpl_pkg::StFind) ? expl_near : scan_cnt_q;

  // Table memories with registered reads. The valid bits make an
  // entry that was never written since the last clear read as zero.
  bpl_pkg::entry_t mut_mem  [Buckets];
  bpl_pkg::entry_t expl_mem [Buckets];
  bpl_pkg::entry_t mut_rd_q, expl_rd_q;
  bpl_pkg::entry_t mut_wdata, expl_wdata;
  logic [Buckets-1:0] mut_vld_q, expl_vld_q;
  logic               mut_rvld_q, expl_rvld_q;
  bpl_pkg::entry_t    mut_eff, expl_eff;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mut_mem[mut_idx_q]   <= mut_wdata;
      expl_mem[expl_idx_q] <= expl_wdata;
    end
    mut_rd_q  <= mut_mem[mut_raddr];
    expl_rd_q <= expl_mem[expl_raddr];
  end

  assign mut_eff  = mut_rvld_q  ? mut_rd_q  : '0;
  assign expl_eff = expl_rvld_q ? expl_rd_q : '0;

  // Moving-average update: avg + floor(lr * (fitness - avg) / 65536).
  logic [LrW-1:0]          lr_eff;
  logic signed [FitW:0]    mut_diff, expl_diff;
  logic signed [ProdW-1:0] mut_prod_q, expl_prod_q;
  logic signed [ProdW-1:0] mut_delta, expl_delta;
  bpl_pkg::entry_t         mut_old_q, expl_old_q;
  logic                    mut_first_q, expl_first_q;

  assign lr_eff    = lr_q[LrW-1] ? bpl_pkg::LrOne : lr_q;
  assign mut_diff  = $signed({fit_q[FitW-1], fit_q}) -
                     $signed({mut_eff.avg[FitW-1], mut_eff.avg});
  assign expl_diff = $signed({fit_q[FitW-1], fit_q}) -
                     $signed({expl_eff.avg[FitW-1], expl_eff.avg});

  always_ff @(posedge clk_i) begin
    if (state_q == bpl_pkg::StCalc) begin
      mut_prod_q   <= $signed({1'b0, lr_eff}) * mut_diff;
      expl_prod_q  <= $signed({1'b0, lr_eff}) * expl_diff;
      mut_old_q    <= mut_eff;
      expl_old_q   <= expl_eff;
      mut_first_q  <= (mut_eff.count == '0);
      expl_first_q <= (expl_eff.count == '0);
    end
  end

  assign mut_delta  = mut_prod_q >>> 16;
  assign expl_delta = expl_prod_q >>> 16;

  always_comb begin
    if (mut_first_q) begin
      mut_wdata.count = CntW'(1);
      mut_wdata.avg   = fit_q;
    end else begin
      mut_wdata.count = (mut_old_q.count == bpl_pkg::CntMax) ? bpl_pkg::CntMax :
                        mut_old_q.count + CntW'(1);
      mut_wdata.avg   = mut_old_q.avg + mut_delta[FitW-1:0];
    end
    if (expl_first_q) begin
      expl_wdata.count = CntW'(1);
      expl_wdata.avg   = fit_q;
    end else begin
      expl_wdata.count = (expl_old_q.count == bpl_pkg::CntMax) ? bpl_pkg::CntMax :
                         expl_old_q.count + CntW'(1);
      expl_wdata.avg   = expl_old_q.avg + expl_delta[FitW-1:0];
    end
  end

  // Recommendation scan: running best over entries as they are read back.
  // A strictly greater average replaces the best, so the lower index wins ties.
  logic            mut_found_q, expl_found_q;
  logic [FitW-1:0] mut_best_q, expl_best_q;
  logic [IdxW-1:0] mut_bidx_q, expl_bidx_q;
  logic            mut_take, expl_take;

  assign mut_take  = cmp_en_q && (mut_eff.count >= min_q) &&
                     (!mut_found_q || ($signed(mut_eff.avg) > $signed(mut_best_q)));
  assign expl_take = cmp_en_q && (expl_eff.count >= min_q) &&
                     (!expl_found_q || ($signed(expl_eff.avg) > $signed(expl_best_q)));

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      act_q      <= s_axis_tuser;
      mut_val_q  <= s_axis_tdata[RateW-1:0];
      expl_val_q <= s_axis_tdata[2*RateW-1:RateW];
      fit_q      <= s_axis_tdata[2*RateW+FitW-1:2*RateW];
    end
    if (state_q == bpl_pkg::StFind) begin
      mut_idx_q  <= mut_near;
      expl_idx_q <= expl_near;
    end
    cmp_idx_q <= scan_cnt_q;
    if (mut_take) begin
      mut_best_q <= mut_eff.avg;
      mut_bidx_q <= cmp_idx_q;
    end
    if (expl_take) begin
      expl_best_q <= expl_eff.avg;
      expl_bidx_q <= cmp_idx_q;
    end
    if (out_load) begin
      out_user_q <= observed_q && mut_found_q && expl_found_q;
      out_data_q <= (observed_q && mut_found_q && expl_found_q) ?
                    {expl_ctr[expl_bidx_q], mut_ctr[mut_bidx_q]} : '0;
    end
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpl_pkg::StIdle;
      lr_q         <= bpl_pkg::LrReset;
      min_q        <= bpl_pkg::MinReset;
      observed_q   <= 1'b0;
      scan_cnt_q   <= '0;
      cmp_en_q     <= 1'b0;
      mut_vld_q    <= '0;
      expl_vld_q   <= '0;
      mut_rvld_q   <= 1'b0;
      expl_rvld_q  <= 1'b0;
      mut_found_q  <= 1'b0;
      expl_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      lr_q        <= lr_d;
      min_q       <= min_d;
      observed_q  <= observed_d;
      scan_cnt_q  <= scan_cnt_d;
      cmp_en_q    <= (state_q == bpl_pkg::StScan);
      mut_rvld_q  <= mut_vld_q[mut_raddr];
      expl_rvld_q <= expl_vld_q[expl_raddr];
      out_valid_q <= out_valid_d;
      if (s_hs && s_axis_tuser == bpl_pkg::ActClear) begin
        mut_vld_q  <= '0;
        expl_vld_q <= '0;
      end else if (mem_we && act_q == bpl_pkg::ActObserve) begin
        mut_vld_q[mut_idx_q]   <= 1'b1;
        expl_vld_q[expl_idx_q] <= 1'b1;
      end
      if (state_q == bpl_pkg::StWrite) begin
        mut_found_q  <= 1'b0;
        expl_found_q <= 1'b0;
      end else begin
        if (mut_take) begin
          mut_found_q <= 1'b1;
        end
        if (expl_take) begin
          expl_found_q <= 1'b1;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/core/bpl_checker.sv =====
`timescale 1ns / 1ps

module bpl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [bpl_pkg::InDataW-1:0]    s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bpl_pkg::OutDataW-1:0]   m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [bpl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input logic [bpl_pkg::CfgDataW-1:0]   cfg_data_i
);

  // One beat at a time: the input side closes right after a beat is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while a beat is in work");

  // A result without a recommendation carries zero centres.
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("centres nonzero on an invalid result");

  // A new result is only loaded while the block is busy with a beat.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a beat in work");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule

bind bucketed_parameter_learner bpl_checker u_bpl_checker (.*);
